/* rtl/style_value_keyword_filter_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the style value keyword filter.
// ----------------------------------------------------------------------------
`ifndef STYLE_VALUE_KEYWORD_FILTER_CORE_ASSERT_SVH
`define STYLE_VALUE_KEYWORD_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define SVKF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SVKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/svkf_pkg.sv */
// ----------------------------------------------------------------------------
// svkf_pkg
// Types, constants and keyword tables of the style value keyword filter.
// ----------------------------------------------------------------------------
package svkf_pkg;

  localparam int unsigned WindowDepth  = 10;
  localparam int unsigned KwCount      = 3;
  localparam int unsigned KwBits       = 88;
  localparam int unsigned CountW       = 17;
  localparam logic [CountW-1:0] CountLimit = 17'h10000;
  localparam logic [15:0] MaxLengthReset   = 16'd8192;
  localparam logic [7:0]  FoldOffset       = 8'd32;

  localparam int unsigned KwLen [KwCount] = '{11, 9, 11};
  localparam logic [KwBits-1:0] KwText [KwCount] = '{
    KwBits'("expression("),
    KwBits'("behavior:"),
    KwBits'("javascript:")
  };

  typedef enum logic [1:0] {
    VERDICT_ACCEPT   = 2'd0,
    VERDICT_EMPTY    = 2'd1,
    VERDICT_TOO_LONG = 2'd2,
    VERDICT_KEYWORD  = 2'd3
  } verdict_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic       care;
    logic [7:0] ch;
  } kw_tap_t;

  // expected character of keyword k at window position pos (0 = most recent)
  function automatic kw_tap_t kw_tap(input int unsigned k, input int unsigned pos);
    kw_tap_t t;
    int      j;
    t.care = 1'b0;
    t.ch   = '0;
    j = int'(KwLen[k]) - 2 - int'(pos);
    if (j >= 0) begin
      t.care = 1'b1;
      t.ch   = KwText[k][8*(int'(KwLen[k])-1-j) +: 8];
    end
    return t;
  endfunction

  function automatic logic [7:0] kw_last(input int unsigned k);
    return KwText[k][7:0];
  endfunction

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5a) begin
      return b + FoldOffset;
    end
    return b;
  endfunction

endpackage

/* rtl/style_value_keyword_filter_core.sv */
// ----------------------------------------------------------------------------
// style_value_keyword_filter_core
// Screens a style value byte stream for emptiness, length and keywords.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one word per cycle: a byte with
// carries_byte_i set, and/or an end marker with is_last_i set. A word with
// neither is ignored. Each ending word yields one verdict word on the output
// channel (out_valid_o/out_ready_i), registered, in the cycle after acceptance.
// Throughput is one word per cycle, set by a ten-cell shift window whose
// cells compare their bytes against the three keywords in parallel.
// The verdict register parts the two sides: input is taken while a verdict
// waits, and only stalls when a verdict is held and out_ready_i is low.
// cfg_max_length_i is written through cfg_valid_i (always ready); write it
// only while idle. Reset clears the window, count and flag, drops any pending
// verdict and sets the limit to 8192.
// ----------------------------------------------------------------------------
`include "style_value_keyword_filter_core_assert.svh"

module style_value_keyword_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        carries_byte_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_max_length_i
);

  localparam int unsigned Depth = svkf_pkg::WindowDepth;
  localparam int unsigned NKw   = svkf_pkg::KwCount;

  logic                            in_acc;
  logic [7:0]                      fold_b;
  svkf_pkg::cell_ctrl_t            ctrl;
  logic [7:0]                      win [Depth];
  logic [NKw-1:0]                  hits [Depth];
  logic [NKw-1:0]                  kw_hit;
  logic [svkf_pkg::CountW-1:0]     cnt_q, cnt_d, cnt_new;
  logic                            seen_q, seen_d, seen_new;
  logic [15:0]                     max_len_q;
  logic                            out_valid_q;
  svkf_pkg::verdict_e              verdict_q, verdict_new;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign fold_b      = svkf_pkg::fold_byte(data_byte_i);

  assign ctrl.shift = in_acc && carries_byte_i;
  assign ctrl.clear = in_acc && is_last_i;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [7:0] feed;
    if (i == 0) begin : g_head
      assign feed = fold_b;
    end else begin : g_body
      assign feed = win[i-1];
    end
    svkf_cell #(.Pos(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .byte_i (feed),
      .byte_o (win[i]),
      .hit_o  (hits[i])
    );
  end

  always_comb begin
    for (int k = 0; k < NKw; k++) begin
      kw_hit[k] = (fold_b == svkf_pkg::kw_last(k));
      for (int i = 0; i < Depth; i++) begin
        kw_hit[k] = kw_hit[k] && hits[i][k];
      end
    end
  end

  always_comb begin
    cnt_new  = cnt_q;
    seen_new = seen_q;
    if (carries_byte_i) begin
      seen_new = seen_q || (|kw_hit);
      if (cnt_q != svkf_pkg::CountLimit) begin
        cnt_new = cnt_q + 1'b1;
      end
    end
    if (cnt_new == '0) begin
      verdict_new = svkf_pkg::VERDICT_EMPTY;
    end else if (cnt_new > {1'b0, max_len_q}) begin
      verdict_new = svkf_pkg::VERDICT_TOO_LONG;
    end else if (seen_new) begin
      verdict_new = svkf_pkg::VERDICT_KEYWORD;
    end else begin
      verdict_new = svkf_pkg::VERDICT_ACCEPT;
    end
    cnt_d  = cnt_q;
    seen_d = seen_q;
    if (in_acc) begin
      if (is_last_i) begin
        cnt_d  = '0;
        seen_d = 1'b0;
      end else begin
        cnt_d  = cnt_new;
        seen_d = seen_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      max_len_q   <= svkf_pkg::MaxLengthReset;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      if (cfg_valid_i) begin
        max_len_q <= cfg_max_length_i;
      end
      if (in_acc && is_last_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_last_i) begin
      verdict_q <= verdict_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  `SVKF_ASSERT_NEXT(a_last_gives_word, clk_i, rst_ni, in_acc && is_last_i, out_valid_o)
  `SVKF_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, in_acc && is_last_i,
                    cnt_q == '0 && !seen_q)
  `SVKF_ASSERT_NEXT(a_count_step, clk_i, rst_ni,
                    in_acc && carries_byte_i && !is_last_i && cnt_q != svkf_pkg::CountLimit,
                    cnt_q == $past(cnt_q) + 1'b1)

endmodule

/* rtl/svkf_cell.sv */
// ----------------------------------------------------------------------------
// svkf_cell
// One window position: holds a folded byte, passes it on, flags keyword hits.
// ----------------------------------------------------------------------------
module svkf_cell #(
  parameter int unsigned Pos = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  svkf_pkg::cell_ctrl_t             ctrl_i,
  input  logic [7:0]                       byte_i,
  output logic [7:0]                       byte_o,
  output logic [svkf_pkg::KwCount-1:0]     hit_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

  for (genvar k = 0; k < svkf_pkg::KwCount; k++) begin : g_kw
    localparam svkf_pkg::kw_tap_t Tap = svkf_pkg::kw_tap(k, Pos);
    assign hit_o[k] = !Tap.care || (byte_q == Tap.ch);
  end

endmodule

/* tb/style_value_keyword_filter_core_tb.sv */
// ----------------------------------------------------------------------------
// style_value_keyword_filter_core_tb
// Drives style values into the filter word by word. Byte values, end markers
// and idle words are mixed with random gaps and receiver stalls. A tracker
// object keeps its own window, count and flag. It works out each verdict when
// the ending word is taken and compares every verdict word with the oldest
// one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module style_value_keyword_filter_core_tb;

  class value_screen;
    logic [7:0]                  window [10];
    logic [svkf_pkg::CountW-1:0] count;
    bit                          hit;
    logic [15:0]                 max_len;
    svkf_pkg::verdict_e          due_verdicts [$];
    int                          errors;
    string                       keywords [3];

    function new();
      keywords[0] = "expression(";
      keywords[1] = "behavior:";
      keywords[2] = "javascript:";
      max_len = svkf_pkg::MaxLengthReset;
      errors = 0;
      restart();
    endfunction

    function void restart();
      foreach (window[i]) window[i] = 8'h00;
      count = '0;
      hit = 1'b0;
    endfunction

    function bit ends_keyword(int k, logic [7:0] b);
      int n;
      bit ok;
      n = keywords[k].len();
      ok = (keywords[k][n-1] == b);
      for (int i = 1; i < n; i++) begin
        if (keywords[k][n-1-i] != window[i-1]) ok = 1'b0;
      end
      return ok;
    endfunction

    function void take_word(bit carries, logic [7:0] data, bit last);
      logic [7:0]         b;
      svkf_pkg::verdict_e v;
      if (carries) begin
        b = (data >= 8'h41 && data <= 8'h5a) ? data + 8'd32 : data;
        for (int k = 0; k < 3; k++) begin
          if (ends_keyword(k, b)) hit = 1'b1;
        end
        for (int i = 9; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        if (count < svkf_pkg::CountLimit) count = count + 1'b1;
      end
      if (last) begin
        if (count == 0) v = svkf_pkg::VERDICT_EMPTY;
        else if (count > {1'b0, max_len}) v = svkf_pkg::VERDICT_TOO_LONG;
        else if (hit) v = svkf_pkg::VERDICT_KEYWORD;
        else v = svkf_pkg::VERDICT_ACCEPT;
        due_verdicts = {due_verdicts, v};
        restart();
      end
    endfunction

    function void match_verdict(logic [1:0] got);
      svkf_pkg::verdict_e want;
      if (due_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict word, expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = due_verdicts.pop_front();
        if (got !== want) begin
          $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        carries_byte_i;
  logic [7:0]  data_byte_i;
  logic        is_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  verdict_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_max_length_i;

  value_screen screen;
  bit          steady;
  bit          hold_req;
  int          words_sent;
  logic [7:0]  value_bytes [$];
  string       kw_text [3] = '{"expression(", "behavior:", "javascript:"};

  style_value_keyword_filter_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .carries_byte_i   (carries_byte_i),
    .data_byte_i      (data_byte_i),
    .is_last_i        (is_last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .verdict_o        (verdict_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_max_length_i (cfg_max_length_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // monitor: verdict before input word, so a stray word is never masked by a new expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) screen.max_len = cfg_max_length_i;
      if (out_valid_o && out_ready_i) screen.match_verdict(verdict_o);
      if (in_valid_i && in_ready_o) screen.take_word(carries_byte_i, data_byte_i, is_last_i);
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  task automatic send_word(input bit c, input logic [7:0] d, input bit l);
    if (!steady && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    carries_byte_i <= c;
    data_byte_i    <= d;
    is_last_i      <= l;
    do @(posedge clk_i); while (!in_ready_o);
    if (c || l) words_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (screen.due_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    settle();
    cfg_valid_i      <= 1'b1;
    cfg_max_length_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] mixed_case(input logic [7:0] ch);
    if (ch >= "a" && ch <= "z" && $urandom_range(1)) return ch - 8'd32;
    return ch;
  endfunction

  task automatic random_fill(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(9);
      if (r < 4) value_bytes = {value_bytes, 8'($urandom_range("z", "a"))};
      else if (r < 6) value_bytes = {value_bytes, 8'($urandom_range("Z", "A"))};
      else if (r < 7) value_bytes = {value_bytes, ($urandom_range(1) ? 8'h3a : 8'h28)};
      else value_bytes = {value_bytes, 8'($urandom_range(255))};
    end
  endtask

  task automatic send_value(input bit bare_end);
    int n;
    n = value_bytes.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) send_word(1'b0, 8'($urandom_range(255)), 1'b0);
      send_word(1'b1, value_bytes[i], !bare_end && i == n - 1);
    end
    if (bare_end || n == 0) send_word(1'b0, 8'($urandom_range(255)), 1'b1);
    value_bytes.delete();
  endtask

  // value with a keyword, a spoilt keyword or none, at a random place
  task automatic random_value(input int max_bytes);
    int n, k, klen, pos, r;
    n = $urandom_range(max_bytes);
    r = $urandom_range(99);
    k = $urandom_range(2);
    klen = kw_text[k].len();
    if (r < 65 && n < klen) n = klen + $urandom_range(3);
    random_fill(n);
    if (r < 65) begin
      pos = $urandom_range(n - klen);
      for (int j = 0; j < klen; j++) value_bytes[pos+j] = mixed_case(kw_text[k][j]);
      if (r >= 50) value_bytes[pos + $urandom_range(klen - 1)] = 8'($urandom_range(255));
    end
    send_value($urandom_range(1));
  endtask

  // keyword cut across two values: must not match
  task automatic split_keyword();
    int k, klen, cut;
    k = $urandom_range(2);
    klen = kw_text[k].len();
    cut = $urandom_range(klen - 1, 1);
    random_fill($urandom_range(5));
    for (int j = 0; j < cut; j++) value_bytes = {value_bytes, mixed_case(kw_text[k][j])};
    send_value($urandom_range(1));
    for (int j = cut; j < klen; j++) value_bytes = {value_bytes, mixed_case(kw_text[k][j])};
    random_fill($urandom_range(4));
    send_value($urandom_range(1));
  endtask

  task automatic run_phase(input int target, input int max_bytes);
    int start, r;
    start = words_sent;
    while (words_sent - start < target) begin
      r = $urandom_range(99);
      if (r < 70) random_value(max_bytes);
      else if (r < 80) split_keyword();
      else if (r < 90) send_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                                 $urandom_range(99) < 15);
      else send_word(1'b1, 8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic long_value(input int n);
    for (int i = 0; i < n; i++) begin
      send_word(1'b1, 8'($urandom_range("z", "a")), i == n - 1);
    end
  endtask

  initial begin
    string shout;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    carries_byte_i   = 1'b0;
    data_byte_i      = 8'h00;
    is_last_i        = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_max_length_i = 16'h0000;
    steady           = 1'b0;
    hold_req         = 1'b0;
    words_sent       = 0;
    screen = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty, idle word, single byte, upper case keyword, extreme bytes, zero limit
    send_word(1'b0, 8'h00, 1'b1);
    send_word(1'b0, 8'hff, 1'b0);
    send_word(1'b0, 8'h5a, 1'b1);
    send_word(1'b1, 8'h41, 1'b1);
    shout = "BEHAVIOR:";
    for (int j = 0; j < shout.len(); j++) send_word(1'b1, shout[j], j == shout.len() - 1);
    send_word(1'b1, 8'hff, 1'b0);
    send_word(1'b1, 8'h00, 1'b0);
    send_word(1'b0, 8'h00, 1'b1);
    write_limit(16'h0000);
    send_word(1'b1, 8'h7f, 1'b1);
    send_word(1'b0, 8'h00, 1'b1);

    run_phase(60, 16);
    write_limit(16'd12);
    run_phase(150, 30);
    write_limit(16'd1);
    hold_req = 1'b1;
    run_phase(100, 4);
    write_limit(16'd20);
    steady = 1'b1;
    run_phase(120, 24);
    steady = 1'b0;
    write_limit(16'($urandom_range(65535)));
    run_phase(150, 16);

    // length limit: exactly at the limit, then one byte past it
    write_limit(16'd30);
    long_value(30);
    long_value(31);
    run_phase(40, 16);

    settle();
    if (screen.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/svkf_pkg.sv
rtl/svkf_cell.sv
rtl/style_value_keyword_filter_core.sv
tb/style_value_keyword_filter_core_tb.sv
